// File: design/wpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wpc_pkg;

  localparam int WAYPOINTS = 8;
  localparam int SLOT_W    = $clog2(WAYPOINTS);
  localparam int CNT_W     = SLOT_W + 1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_KP_VELOCITY    = 3'd0;
  localparam logic [2:0] REG_KI_VELOCITY    = 3'd1;
  localparam logic [2:0] REG_KD_GAIN        = 3'd2;
  localparam logic [2:0] REG_KP_TURN        = 3'd3;
  localparam logic [2:0] REG_K_RANGE        = 3'd4;
  localparam logic [2:0] REG_K_HEADING      = 3'd5;
  localparam logic [2:0] REG_VELOCITY_MAX   = 3'd6;
  localparam logic [2:0] REG_WAYPOINT_COUNT = 3'd7;

  // Fixed-point constants
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [19:0] PI_Q16     = 20'sd205887;
  localparam logic [24:0]        NEAR_Q8    = 25'd5120;
  localparam logic [15:0]        VSET_MIN   = 16'd256;
  localparam int SQRT_STEPS   = 25;
  localparam int CORDIC_STEPS = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQSUM, S_ITER, S_VMUL, S_WMUL, S_ERR,
    S_TV0, S_TV1, S_TV2, S_TW0, S_TW1, S_OUT
  } state_e;

  // CORDIC arctangent table, Q.16 radians
  function automatic logic signed [19:0] cordic_angle(input logic [3:0] i);
    logic signed [19:0] a;
    case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30386;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      4'd15:   a = 20'sd2;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

  // Waypoint store contents after reset, Q16.8 metres
  function automatic logic signed [23:0] init_east(input int i);
    logic signed [23:0] v;
    case (i)
      0, 1, 2, 3: v = 24'sd1203200;
      4:          v = 24'sd1152000;
      default:    v = 24'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] init_north(input int i);
    logic signed [23:0] v;
    case (i)
      0:       v = 24'sd1203200;
      1:       v = 24'sd1024000;
      2:       v = 24'sd896000;
      3, 4:    v = 24'sd768000;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/waypoint_pd_thrust_controller.sv
// A waypoint load returns no result. An odometry request steps through the
// square, root, gain, error and thrust states, then registers its result.
// No request is taken while the block is busy; the 25-step square root,
// run beside the 16-step CORDIC, and the shared 41x26 multiplier set the pace.
// Reset: gains, waypoint store, goal index and loop history take their
// reset values at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_pd_thrust_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic [2:0]          waypoint_slot_i,
  input  wire logic signed [23:0]  east_pos_i,
  input  wire logic signed [23:0]  north_pos_i,
  input  wire logic signed [14:0]  heading_i,
  input  wire logic signed [15:0]  speed_i,
  input  wire logic signed [15:0]  yaw_rate_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       left_thrust_o,
  output logic signed [31:0]       right_thrust_o,
  output logic [23:0]              range_to_goal_o,
  output logic [2:0]               goal_index_o,
  output logic                     goal_reached_o
);
  import wpc_pkg::*;

  // Configuration registers
  logic [15:0] kp_v_q, ki_v_q, kd_q, kp_t_q, k_range_q, k_heading_q;
  logic [14:0] vmax_q;
  logic [3:0]  wp_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_v_q      <= 16'd8000;
      ki_v_q      <= 16'd0;
      kd_q        <= 16'd1600;
      kp_t_q      <= 16'd8000;
      k_range_q   <= 16'd240;
      k_heading_q <= 16'd160;
      vmax_q      <= 15'd1152;
      wp_count_q  <= 4'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KP_VELOCITY:    kp_v_q      <= cfg_wdata_i;
        REG_KI_VELOCITY:    ki_v_q      <= cfg_wdata_i;
        REG_KD_GAIN:        kd_q        <= cfg_wdata_i;
        REG_KP_TURN:        kp_t_q      <= cfg_wdata_i;
        REG_K_RANGE:        k_range_q   <= cfg_wdata_i;
        REG_K_HEADING:      k_heading_q <= cfg_wdata_i;
        REG_VELOCITY_MAX:   vmax_q      <= cfg_wdata_i[14:0];
        REG_WAYPOINT_COUNT: wp_count_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic   accept, odo_req, load_req;
  logic   out_load;
  logic [4:0] iter_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign odo_req  = accept && cmd_i;
  assign load_req = accept && !cmd_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (odo_req) state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SQSUM;
      S_SQSUM: state_d = S_ITER;
      S_ITER:  if (iter_q == 5'(SQRT_STEPS - 1)) state_d = S_VMUL;
      S_VMUL:  state_d = S_WMUL;
      S_WMUL:  state_d = S_ERR;
      S_ERR:   state_d = S_TV0;
      S_TV0:   state_d = S_TV1;
      S_TV1:   state_d = S_TV2;
      S_TV2:   state_d = S_TW0;
      S_TW0:   state_d = S_TW1;
      S_TW1:   state_d = S_OUT;
      S_OUT:   if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Goal selection and waypoint store
  logic signed [23:0] wp_east_q  [WAYPOINTS];
  logic signed [23:0] wp_north_q [WAYPOINTS];
  logic [2:0]  goal_q, goal_eff;
  logic [3:0]  cnt_eff;

  always_comb begin
    cnt_eff = wp_count_q;
    if (wp_count_q == 4'd0) cnt_eff = 4'd1;
    if (wp_count_q > 4'(WAYPOINTS)) cnt_eff = 4'(WAYPOINTS);
    goal_eff = goal_q;
    if ({1'b0, goal_q} >= cnt_eff) goal_eff = 3'(cnt_eff - 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WAYPOINTS; i++) begin
        wp_east_q[i]  <= init_east(i);
        wp_north_q[i] <= init_north(i);
      end
    end else if (load_req) begin
      wp_east_q[waypoint_slot_i]  <= east_pos_i;
      wp_north_q[waypoint_slot_i] <= north_pos_i;
    end
  end

  // Offsets to the goal
  logic signed [24:0] dx_c, dy_c;
  assign dx_c = 25'(wp_east_q[goal_eff])  - 25'(east_pos_i);
  assign dy_c = 25'(wp_north_q[goal_eff]) - 25'(north_pos_i);

  // Shared multiplier, operands picked per state
  logic signed [40:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [66:0] prod_q;

  logic signed [24:0] dx_q, dy_q;
  logic [24:0]        root_q;
  logic signed [15:0] e_q;
  logic signed [17:0] ev_q;
  logic signed [18:0] dv_q;
  logic signed [25:0] ew_q;
  logic signed [26:0] dw_q;
  logic signed [39:0] sum_q;

  always_comb begin
    mul_a = 41'sd0;
    mul_b = 26'sd0;
    case (state_q)
      S_SQX: begin
        mul_a = 41'(dx_q);
        mul_b = 26'(dx_q);
      end
      S_SQY: begin
        mul_a = 41'(dy_q);
        mul_b = 26'(dy_q);
      end
      S_VMUL: begin
        mul_a = $signed({16'd0, root_q});
        mul_b = $signed({10'd0, k_range_q});
      end
      S_WMUL: begin
        mul_a = 41'(e_q);
        mul_b = $signed({10'd0, k_heading_q});
      end
      S_TV0: begin
        mul_a = 41'(ev_q);
        mul_b = $signed({10'd0, kp_v_q});
      end
      S_TV1: begin
        mul_a = 41'(sum_q);
        mul_b = $signed({10'd0, ki_v_q});
      end
      S_TV2: begin
        mul_a = 41'(dv_q);
        mul_b = $signed({10'd0, kd_q});
      end
      S_TW0: begin
        mul_a = 41'(ew_q);
        mul_b = $signed({10'd0, kp_t_q});
      end
      S_TW1, S_OUT: begin
        mul_a = 41'(dw_q);
        mul_b = $signed({10'd0, kd_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  // Input-side outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    out_load   = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);
  end

  // Square root, two radicand bits per step
  logic [49:0] n_q;
  logic [27:0] rem_q, rem_sh, trial;
  logic        take;

  always_comb begin
    rem_sh = {rem_q[25:0], n_q[49:48]};
    trial  = {1'b0, root_q, 2'b01};
    take   = (rem_sh >= trial);
  end

  // CORDIC vectoring step
  logic signed [47:0] x_q, y_q, xs, ys;
  logic signed [19:0] z_q;
  logic               zero_q;
  logic [3:0]         cidx;

  assign cidx = iter_q[3:0];
  assign xs   = x_q >>> cidx;
  assign ys   = y_q >>> cidx;

  logic signed [47:0] x0, y0;
  assign x0 = $signed({{3{dx_c[24]}}, dx_c, 20'd0});
  assign y0 = $signed({{3{dy_c[24]}}, dy_c, 20'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= 5'd0;
    end else if (state_q == S_SQSUM) begin
      iter_q <= 5'd0;
    end else if (state_q == S_ITER) begin
      iter_q <= iter_q + 5'd1;
    end
  end

  // Per-request item registers
  logic signed [14:0] hd_q;
  logic signed [15:0] sp_q, wr_q;

  always_ff @(posedge clk_i) begin
    if (odo_req) begin
      dx_q   <= dx_c;
      dy_q   <= dy_c;
      hd_q   <= heading_i;
      sp_q   <= speed_i;
      wr_q   <= yaw_rate_i;
      zero_q <= (dx_c == 25'sd0) && (dy_c == 25'sd0);
      if (dx_c < 0) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= (dy_c >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= 20'sd0;
      end
    end else if (state_q == S_ITER && iter_q < 5'(CORDIC_STEPS)) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + cordic_angle(cidx);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - cordic_angle(cidx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_SQY:   n_q <= prod_q[49:0];
      S_SQSUM: begin
        n_q    <= n_q + prod_q[49:0];
        rem_q  <= 28'd0;
        root_q <= 25'd0;
      end
      S_ITER: begin
        n_q    <= {n_q[47:0], 2'b00};
        rem_q  <= take ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[23:0], take};
      end
      default: ;
    endcase
  end

  // Bearing error, wrapped to [-pi, pi]
  logic signed [16:0] bearing;
  logic signed [17:0] ang, ang1, ang2;
  logic signed [19:0] zr;

  always_comb begin
    zr      = (z_q + 20'sd8) >>> 4;
    bearing = zero_q ? 17'sd0 : zr[16:0];
    ang     = 18'(bearing) - 18'(hd_q);
    ang1    = ang;
    if (ang > 0 && ang >= TWO_PI_Q12) ang1 = ang - TWO_PI_Q12;
    else if (ang < 0 && ang <= -TWO_PI_Q12) ang1 = ang + TWO_PI_Q12;
    ang2 = ang1;
    if (ang1 > PI_Q12) ang2 = ang1 - TWO_PI_Q12;
    else if (ang1 < -PI_Q12) ang2 = ang1 + TWO_PI_Q12;
  end

  // Speed setpoint and goal test
  logic [15:0] vset_q, vset_c;
  logic        near_q;
  logic [36:0] vraw;

  always_comb begin
    vraw = prod_q[40:4];
    if (vraw > {22'd0, vmax_q})        vset_c = {1'b0, vmax_q};
    else if (vraw < {21'd0, VSET_MIN}) vset_c = VSET_MIN;
    else                               vset_c = vraw[15:0];
    if (root_q < NEAR_Q8) vset_c = 16'd0;
  end

  // Loop errors
  logic signed [24:0] wset;
  logic signed [17:0] ev_c, last_ev_q;
  logic signed [25:0] ew_c, last_ew_q;
  logic signed [40:0] sum_c;
  logic signed [39:0] sum_sat;

  always_comb begin
    wset  = prod_q[32:8];
    ev_c  = $signed({2'b00, vset_q}) - 18'(sp_q);
    ew_c  = 26'(wset) - 26'(wr_q);
    sum_c = 41'(sum_q) + 41'(ev_c);
    if (sum_c > 41'sh0_7F_FFFF_FFFF)       sum_sat = 40'sh7F_FFFF_FFFF;
    else if (sum_c < -41'sh0_80_0000_0000) sum_sat = 40'sh80_0000_0000;
    else                                   sum_sat = sum_c[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q    <= 3'd0;
      last_ev_q <= 18'sd0;
      last_ew_q <= 26'sd0;
      sum_q     <= 40'sd0;
    end else if (odo_req) begin
      goal_q <= goal_eff;
    end else if (state_q == S_ERR) begin
      last_ev_q <= ev_c;
      last_ew_q <= ew_c;
      sum_q     <= sum_sat;
      if (near_q && ({1'b0, goal_q} + 4'd1 < cnt_eff)) goal_q <= goal_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_VMUL: e_q <= ang2[15:0];
      S_WMUL: begin
        vset_q <= vset_c;
        near_q <= (root_q < NEAR_Q8);
      end
      S_ERR: begin
        ev_q <= ev_c;
        dv_q <= 19'(ev_c) - 19'(last_ev_q);
        ew_q <= ew_c;
        dw_q <= 27'(ew_c) - 27'(last_ew_q);
      end
      default: ;
    endcase
  end

  // Thrust accumulation
  logic signed [57:0] acc_q, tw_q, tw_c, lsum, rsum;
  logic signed [53:0] lsh, rsh;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_TV1:        acc_q <= prod_q[57:0];
      S_TV2, S_TW0: acc_q <= acc_q + prod_q[57:0];
      S_TW1:        tw_q  <= prod_q[57:0];
      default: ;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    logic signed [31:0] r;
    if (v > 54'sh7FFF_FFFF)        r = 32'sh7FFF_FFFF;
    else if (v < -54'sh8000_0000)  r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  always_comb begin
    tw_c = tw_q + prod_q[57:0];
    lsum = acc_q - tw_c;
    rsum = acc_q + tw_c;
    lsh  = 54'(lsum >>> 4);
    rsh  = 54'(rsum >>> 4);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_thrust_o   <= sat32(lsh);
      right_thrust_o  <= sat32(rsh);
      range_to_goal_o <= root_q[24] ? 24'hFF_FFFF : root_q[23:0];
      goal_index_o    <= goal_q;
      goal_reached_o  <= near_q;
    end
  end

  // Assertions
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

  a_odo_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    odo_req |=> state_q == S_SQX)
    else $error("odometry request did not start the sequence");

  a_load_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req |=> state_q == S_IDLE)
    else $error("waypoint load left idle");

  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER && iter_q == 5'(SQRT_STEPS - 1)) |=> state_q == S_VMUL)
    else $error("root loop overran");

  a_near_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && goal_reached_o) |-> range_to_goal_o < 24'd5120)
    else $error("goal reached flag with far range");

endmodule
`default_nettype wire

// File: verif/waypoint_pd_thrust_controller_tb.sv
`timescale 1ns / 1ps
module waypoint_pd_thrust_controller_tb;
  import wpc_pkg::*;

  localparam int SETTLE_CYCLES = 45;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 7;
  localparam int RAND_PER_PH   = 200;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct {
    logic              cmd;
    logic [2:0]        slot;
    logic signed [23:0] east;
    logic signed [23:0] north;
    logic signed [14:0] hdg;
    logic signed [15:0] spd;
    logic signed [15:0] yrate;
    bit                hand;
    logic [23:0]       h_range;
    logic [2:0]        h_goal;
    logic              h_reached;
  } request_t;

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic [23:0]        range;
    logic [2:0]         goal;
    logic               reached;
  } thrust_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic cmd_i;
  logic [2:0] waypoint_slot_i;
  logic signed [23:0] east_pos_i, north_pos_i;
  logic signed [14:0] heading_i;
  logic signed [15:0] speed_i, yaw_rate_i;
  logic out_valid_o, out_stall_i;
  logic signed [31:0] left_thrust_o, right_thrust_o;
  logic [23:0] range_to_goal_o;
  logic [2:0] goal_index_o;
  logic goal_reached_o;

  waypoint_pd_thrust_controller DUT (.*);

  // Controller mirror: gains, waypoint store and loop history
  longint g_kpv, g_kiv, g_kd, g_kpt, g_krange, g_khead, g_vmax, g_wcount;
  longint wp_east[WAYPOINTS];
  longint wp_north[WAYPOINTS];
  longint goal_idx, prev_ev, prev_ew, ev_sum;
  longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};

  thrust_t thrust_q[$];
  request_t directed_q[$];
  int errors = 0;
  int idle_mode = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void mirror_reset();
    g_kpv = 8000; g_kiv = 0; g_kd = 1600; g_kpt = 8000;
    g_krange = 240; g_khead = 160; g_vmax = 1152; g_wcount = 5;
    for (int i = 0; i < WAYPOINTS; i++) begin
      wp_east[i] = 0;
      wp_north[i] = 0;
    end
    wp_east[0] = 1203200; wp_north[0] = 1203200;
    wp_east[1] = 1203200; wp_north[1] = 1024000;
    wp_east[2] = 1203200; wp_north[2] = 896000;
    wp_east[3] = 1203200; wp_north[3] = 768000;
    wp_east[4] = 1152000; wp_north[4] = 768000;
    goal_idx = 0; prev_ev = 0; prev_ew = 0; ev_sum = 0;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC vectoring, result in Q3.12 radians
  function automatic longint bearing(input longint dx, input longint dy);
    longint x, y, z, t;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 1048576;
    y = dy * 1048576;
    z = 0;
    if (dx < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? 205887 : -205887;
    end
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + atan_tab[i];
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - atan_tab[i];
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic longint wrap_pi(input longint a);
    longint mag, turns;
    mag = (a < 0) ? -a : a;
    turns = mag / 25736;
    if (a > 0) a = a - turns * 25736;
    else a = a + turns * 25736;
    if (a > 12868) a = a - 25736;
    else if (a < -12868) a = a + 25736;
    return a;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void mirror_config(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_KP_VELOCITY:    g_kpv = val;
      REG_KI_VELOCITY:    g_kiv = val;
      REG_KD_GAIN:        g_kd = val;
      REG_KP_TURN:        g_kpt = val;
      REG_K_RANGE:        g_krange = val;
      REG_K_HEADING:      g_khead = val;
      REG_VELOCITY_MAX:   g_vmax = val[14:0];
      REG_WAYPOINT_COUNT: g_wcount = val[3:0];
      default: ;
    endcase
  endfunction

  // Applies one request to the mirror; returns 1 with the thrust result for a sample
  function automatic bit steer(input request_t rq, output thrust_t res);
    longint dx, dy, vset, wset, ev, ew, tv, tw, cnt;
    longint unsigned rho;
    bit near;
    if (rq.cmd == CMD_LOAD) begin
      wp_east[rq.slot] = rq.east;
      wp_north[rq.slot] = rq.north;
      return 0;
    end
    cnt = g_wcount;
    if (cnt < 1) cnt = 1;
    if (cnt > WAYPOINTS) cnt = WAYPOINTS;
    if (goal_idx >= cnt) goal_idx = cnt - 1;
    dx = wp_east[goal_idx] - longint'(rq.east);
    dy = wp_north[goal_idx] - longint'(rq.north);
    rho = int_sqrt(longint'(dx * dx + dy * dy));
    vset = longint'((longint'(g_krange) * rho) >> 4);
    if (vset > g_vmax) vset = g_vmax;
    else if (vset < 256) vset = 256;
    wset = (g_khead * wrap_pi(bearing(dx, dy) - longint'(rq.hdg))) >>> 8;
    near = rho < 5120;
    if (near) begin
      vset = 0;
      if (goal_idx + 1 < cnt) goal_idx++;
    end
    ev = vset - longint'(rq.spd);
    ev_sum = ev_sum + ev;
    if (ev_sum > 64'sd549755813887) ev_sum = 64'sd549755813887;
    if (ev_sum < -64'sd549755813888) ev_sum = -64'sd549755813888;
    tv = ev * g_kpv + ev_sum * g_kiv + (ev - prev_ev) * g_kd;
    ew = wset - longint'(rq.yrate);
    tw = ew * g_kpt + (ew - prev_ew) * g_kd;
    prev_ev = ev;
    prev_ew = ew;
    res.left = 32'(sat32((tv - tw) >>> 4));
    res.right = 32'(sat32((tv + tw) >>> 4));
    res.range = (rho > 64'hFFFFFF) ? 24'hFFFFFF : rho[23:0];
    res.goal = goal_idx[2:0];
    res.reached = near;
    return 1;
  endfunction

  task automatic add_row(input logic cmd, input logic [2:0] slot, input int east,
                         input int north, input int hdg, input int spd, input int yrate,
                         input bit hand, input int hr, input int hg, input int hre);
    request_t rq;
    rq.cmd = cmd; rq.slot = slot; rq.east = 24'(east); rq.north = 24'(north);
    rq.hdg = 15'(hdg); rq.spd = 16'(spd); rq.yrate = 16'(yrate);
    rq.hand = hand; rq.h_range = 24'(hr); rq.h_goal = 3'(hg); rq.h_reached = 1'(hre);
    directed_q = {directed_q, rq};
  endtask

  // Random request: mostly samples near the active waypoint, some loads and far fixes
  function automatic request_t random_request();
    request_t rq;
    int sel;
    longint g;
    sel = $urandom_range(99);
    rq = '{default: '0};
    rq.cmd = (sel < 20) ? CMD_LOAD : CMD_SAMPLE;
    rq.slot = 3'($urandom_range(7));
    rq.hdg = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(25736) - 12868);
    rq.spd = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    rq.yrate = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512) - 256);
    if (sel < 70) begin
      g = goal_idx;
      if (g >= WAYPOINTS) g = WAYPOINTS - 1;
      rq.east = 24'(wp_east[g] + $urandom_range(16000) - 8000);
      rq.north = 24'(wp_north[g] + $urandom_range(16000) - 8000);
    end else begin
      rq.east = 24'($urandom);
      rq.north = 24'($urandom);
    end
    return rq;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (idle_mode == 2) begin
      out_stall_i <= ($urandom_range(99) < 72);
    end else if (idle_mode == 3) begin
      out_stall_i <= ($urandom_range(99) < 28);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    thrust_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (thrust_q.size() == 0) begin
        report("unexpected result", range_to_goal_o, 0);
      end else begin
        w = thrust_q.pop_front();
        if (left_thrust_o !== w.left) report("left_thrust", left_thrust_o, w.left);
        if (right_thrust_o !== w.right) report("right_thrust", right_thrust_o, w.right);
        if (range_to_goal_o !== w.range) report("range_to_goal", range_to_goal_o, w.range);
        if (goal_index_o !== w.goal) report("goal_index", goal_index_o, w.goal);
        if (goal_reached_o !== w.reached) report("goal_reached", goal_reached_o, w.reached);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input request_t rq);
    thrust_t res;
    if ((idle_mode == 1 && $urandom_range(99) < 72) ||
        (idle_mode == 3 && $urandom_range(99) < 28)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ((idle_mode == 1 && $urandom_range(99) < 72) ||
             (idle_mode == 3 && $urandom_range(99) < 28)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= rq.cmd;
    waypoint_slot_i <= rq.slot;
    east_pos_i <= rq.east;
    north_pos_i <= rq.north;
    heading_i <= rq.hdg;
    speed_i <= rq.spd;
    yaw_rate_i <= rq.yrate;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (steer(rq, res)) begin
      if (rq.hand) begin
        res.range = rq.h_range;
        res.goal = rq.h_goal;
        res.reached = rq.h_reached;
      end
      thrust_q = {thrust_q, res};
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (thrust_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mirror_config(idx, val);
  endtask

  task automatic program_phase(input int ph);
    logic [15:0] v[8];
    for (int i = 0; i < 8; i++) v[i] = 16'($urandom);
    v[REG_VELOCITY_MAX] = 16'($urandom_range(32767));
    v[REG_WAYPOINT_COUNT] = 16'($urandom_range(15));
    case (ph)
      1: begin
        for (int i = 0; i < 8; i++) v[i] = 16'hFFFF;
        v[REG_VELOCITY_MAX] = 16'h7FFF;
        v[REG_WAYPOINT_COUNT] = 16'd15;
      end
      2: for (int i = 0; i < 8; i++) v[i] = 16'd0;
      3: begin
        v[REG_KP_VELOCITY] = 16'd8000; v[REG_KI_VELOCITY] = 16'd16;
        v[REG_KD_GAIN] = 16'd1600; v[REG_KP_TURN] = 16'd8000;
        v[REG_K_RANGE] = 16'd240; v[REG_K_HEADING] = 16'd160;
        v[REG_VELOCITY_MAX] = 16'd100; v[REG_WAYPOINT_COUNT] = 16'd8;
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; cmd_i = 1'b0; waypoint_slot_i = '0;
    east_pos_i = '0; north_pos_i = '0; heading_i = '0; speed_i = '0; yaw_rate_i = '0;
    out_stall_i = 1'b0;
    mirror_reset();

    // waypoint hits, range saturation, zero offset, 20 m boundary, heading limits
    add_row(CMD_SAMPLE, 0, 1203200, 1203200, 0, 0, 0, 1, 0, 1, 1);
    add_row(CMD_SAMPLE, 0, 1203200, 1024000, 12868, 32767, -32768, 1, 0, 2, 1);
    add_row(CMD_LOAD, 2, 8388607, 8388607, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 0, -8388608, -8388608, -12868, -32768, 32767, 1, 16777215, 2, 0);
    add_row(CMD_SAMPLE, 0, 8388607, 8388607, 0, 100, 0, 1, 0, 3, 1);
    add_row(CMD_LOAD, 7, -8388608, -8388608, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOAD, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 0, 4, 1);
    add_row(CMD_SAMPLE, 0, 1152000, 768000, 0, 0, 0, 1, 0, 4, 1);
    add_row(CMD_SAMPLE, 0, 1177600, 768000, 0, 256, 0, 1, 25600, 4, 0);
    add_row(CMD_SAMPLE, 0, 1177600, 768256, 1000, 256, 10, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 0, 1152000, 762881, 0, 0, 0, 1, 5119, 4, 1);
    add_row(CMD_SAMPLE, 0, 1152000, 762880, 0, 0, 0, 1, 5120, 4, 0);
    add_row(CMD_SAMPLE, 0, 0, 0, 16383, 0, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 0, 1100000, 900000, -3000, -300, 500, 0, 0, 0, 0);
    add_row(CMD_LOAD, 0, 1, -1, 0, 0, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send(directed_q[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        program_phase(ph);
      end
      idle_mode = ph % 4;
      if (ph == 2) hold_cnt = HOLD_CYCLES;
      for (int n = 0; n < RAND_PER_PH; n++) send(random_request());
    end

    idle_mode = 0;
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
design/wpc_pkg.sv
design/waypoint_pd_thrust_controller.sv
verif/waypoint_pd_thrust_controller_tb.sv
